>>> hw/rtl/wpr_pkg.sv
// ----------------------------------------------------------------------------
// wpr_pkg: shared constants and types for the Williams %R block
// Sizes of the bar window, price and result widths, queue job layout and
// the back-end sequencer states.
// ----------------------------------------------------------------------------
package wpr_pkg;

	// window storage
	localparam int MAX_WINDOW  = 64;
	localparam int SLOT_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W       = $clog2(MAX_WINDOW + 1);

	// field widths
	localparam int PRICE_W     = 32;
	localparam int WIN_W       = 7;
	localparam int PCT_W       = 15;
	localparam int QUOT_W      = 14;
	localparam int PROD_W      = PRICE_W + QUOT_W;
	localparam int QBIT_W      = $clog2(QUOT_W);

	// stream widths
	localparam int IN_DATA_W   = 3 * PRICE_W;
	localparam int OUT_DATA_W  = 16;

	// constants
	localparam logic [WIN_W-1:0]  WIN_RESET = 7'd14;
	localparam logic [QUOT_W-1:0] SCALE     = 14'd10000;
	localparam logic [PCT_W-1:0]  PCT_MIN   = PCT_W'(-10000);

	// front/back queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// one classified bar, handed from front to back
	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic [CNT_W-1:0]   span;
		logic [PRICE_W-1:0] high;
		logic [PRICE_W-1:0] low;
		logic [PRICE_W-1:0] close;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} back_state_t;

	typedef enum logic [1:0] {
		KIND_ZERO,
		KIND_MIN,
		KIND_DIV
	} res_kind_t;

	// ring slot offset entries before slot, modulo MAX_WINDOW
	function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] slot,
			input logic [SLOT_W-1:0] offset);
		logic [SLOT_W-1:0] res;
		if (slot >= offset) begin
			res = slot - offset;
		end else begin
			res = SLOT_W'(int'(slot) + MAX_WINDOW - int'(offset));
		end
		return res;
	endfunction

endpackage

>>> hw/rtl/wpr_ram.sv
// ----------------------------------------------------------------------------
// wpr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module wpr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hw/rtl/wpr_front.sv
// ----------------------------------------------------------------------------
// wpr_front: bar intake and classification
// Holds the window register, ring write slot and series bar count; turns
// each accepted bar into a job with its ring slot and scan span.
// ----------------------------------------------------------------------------
module wpr_front import wpr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [WIN_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,   // bar_high, bar_low, bar_close
	input  logic [0:0]           s_tuser,   // new_series
	input  logic                 q_full,
	output logic                 push,
	output job_t                 job
);

	logic [WIN_W-1:0]  window_q;
	logic [SLOT_W-1:0] write_slot_q;
	logic [CNT_W-1:0]  bars_seen_q;

	logic [SLOT_W-1:0] base_slot;
	logic [SLOT_W-1:0] next_slot;
	logic [CNT_W-1:0]  base_seen;
	logic [CNT_W-1:0]  seen_n;
	logic [CNT_W-1:0]  eff_win;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign push      = s_tvalid && s_tready;

	// series restart, ring advance, bar count
	always_comb begin
		base_slot = s_tuser[0] ? '0 : write_slot_q;
		base_seen = s_tuser[0] ? '0 : bars_seen_q;
		next_slot = (base_slot == SLOT_W'(MAX_WINDOW - 1)) ? '0 : base_slot + 1'b1;
		seen_n    = (base_seen == CNT_W'(MAX_WINDOW)) ? base_seen : base_seen + 1'b1;
	end

	// window clamp to 1..MAX_WINDOW
	always_comb begin
		if (window_q == '0) begin
			eff_win = CNT_W'(1);
		end else if (int'(window_q) > MAX_WINDOW) begin
			eff_win = CNT_W'(MAX_WINDOW);
		end else begin
			eff_win = CNT_W'(window_q);
		end
	end

	// job payload
	always_comb begin
		job.slot  = base_slot;
		job.span  = (eff_win < seen_n) ? eff_win : seen_n;
		job.high  = s_tdata[PRICE_W-1:0];
		job.low   = s_tdata[2*PRICE_W-1:PRICE_W];
		job.close = s_tdata[3*PRICE_W-1:2*PRICE_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= WIN_RESET;
			write_slot_q <= '0;
			bars_seen_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_q <= cfg_data;
			end
			if (push) begin
				write_slot_q <= next_slot;
				bars_seen_q  <= seen_n;
			end
		end
	end

endmodule

>>> hw/rtl/wpr_queue.sv
// ----------------------------------------------------------------------------
// wpr_queue: short job queue between front and back
// Register FIFO of QUEUE_DEPTH jobs.
// ----------------------------------------------------------------------------
module wpr_queue import wpr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t job_in,
	output logic full,
	output logic valid,
	output job_t job_out,
	input  logic pop
);

	job_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign job_out = slots_q[rd_ptr_q];

	// payload storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= job_in;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/wpr_back.sv
// ----------------------------------------------------------------------------
// wpr_back: window scan, scaling, division and result register
// Stores the bar in the high/low rings, scans back over the span one entry
// a cycle, then forms -(H-close)*10000/(H-L), bit-serially unless a bound.
// ----------------------------------------------------------------------------
module wpr_back import wpr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  job_t                  q_job,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // percent_r, zero pad
);

	back_state_t state_q, state_n;

	logic [SLOT_W-1:0]  slot_q;
	logic [CNT_W-1:0]   span_q;
	logic [CNT_W-1:0]   k_q;
	logic               pend_q;
	logic [PRICE_W-1:0] hi_q;
	logic [PRICE_W-1:0] lo_q;
	logic [PRICE_W-1:0] close_q;
	logic [PRICE_W-1:0] range_q;
	logic [PRICE_W-1:0] rem_q;
	logic [QUOT_W-1:0]  dlo_q;
	logic [QUOT_W-1:0]  quo_q;
	logic [QBIT_W-1:0]  cnt_q;
	res_kind_t          kind_q;
	logic               out_valid_q;
	logic [PCT_W-1:0]   out_data_q;

	logic [SLOT_W-1:0]  raddr;
	logic [PRICE_W-1:0] h_rd;
	logic [PRICE_W-1:0] l_rd;
	logic               issue;
	logic               scan_done;
	logic               out_load;
	res_kind_t          mul_kind;
	logic [PROD_W-1:0]  prod;
	logic [PRICE_W:0]   div_r2;
	logic [PRICE_W:0]   div_diff;
	logic               div_ge;
	logic [PCT_W-1:0]   res_val;

	// high and low rings
	assign raddr = prev_slot(slot_q, k_q[SLOT_W-1:0]);

	wpr_ram #(.WIDTH(PRICE_W), .DEPTH(MAX_WINDOW)) u_high_ram (
		.clk   (clk),
		.we    (q_pop),
		.waddr (q_job.slot),
		.wdata (q_job.high),
		.raddr (raddr),
		.rdata (h_rd)
	);

	wpr_ram #(.WIDTH(PRICE_W), .DEPTH(MAX_WINDOW)) u_low_ram (
		.clk   (clk),
		.we    (q_pop),
		.waddr (q_job.slot),
		.wdata (q_job.low),
		.raddr (raddr),
		.rdata (l_rd)
	);

	// sequencer outputs
	always_comb begin
		q_pop     = (state_q == ST_IDLE) && q_valid;
		issue     = (state_q == ST_SCAN) && (k_q < span_q);
		scan_done = (state_q == ST_SCAN) && (k_q >= span_q) && !pend_q;
		out_load  = (state_q == ST_DONE) && (!out_valid_q || m_tready);
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (q_valid) state_n = ST_SCAN;
			ST_SCAN: if (scan_done) state_n = ST_MUL;
			ST_MUL:  state_n = (mul_kind == KIND_DIV) ? ST_DIV : ST_DONE;
			ST_DIV:  if (cnt_q == '0) state_n = ST_DONE;
			ST_DONE: if (out_load) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	// special ranges: empty range, close at or above H, close at or below L
	always_comb begin
		if (hi_q <= lo_q || close_q >= hi_q) begin
			mul_kind = KIND_ZERO;
		end else if (close_q <= lo_q) begin
			mul_kind = KIND_MIN;
		end else begin
			mul_kind = KIND_DIV;
		end
		prod = {{QUOT_W{1'b0}}, hi_q - close_q} * {{PRICE_W{1'b0}}, SCALE};
	end

	// one quotient bit per cycle; partial remainder stays below range
	always_comb begin
		div_r2   = {rem_q, dlo_q[cnt_q]};
		div_diff = div_r2 - {1'b0, range_q};
		div_ge   = (div_r2 >= {1'b0, range_q});
	end

	// result encode
	always_comb begin
		case (kind_q)
			KIND_MIN: res_val = PCT_MIN;
			KIND_DIV: res_val = PCT_W'(0) - {1'b0, quo_q};
			default:  res_val = '0;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		if (q_pop) begin
			slot_q  <= q_job.slot;
			span_q  <= q_job.span;
			hi_q    <= q_job.high;
			lo_q    <= q_job.low;
			close_q <= q_job.close;
			k_q     <= CNT_W'(1);
		end
		if (issue) begin
			k_q <= k_q + 1'b1;
		end
		if (state_q == ST_SCAN && pend_q) begin
			if (h_rd > hi_q) hi_q <= h_rd;
			if (l_rd < lo_q) lo_q <= l_rd;
		end
		if (state_q == ST_MUL) begin
			kind_q  <= mul_kind;
			range_q <= hi_q - lo_q;
			rem_q   <= prod[PROD_W-1:QUOT_W];
			dlo_q   <= prod[QUOT_W-1:0];
			quo_q   <= '0;
			cnt_q   <= QBIT_W'(QUOT_W - 1);
		end
		if (state_q == ST_DIV) begin
			rem_q        <= div_ge ? div_diff[PRICE_W-1:0] : div_r2[PRICE_W-1:0];
			quo_q[cnt_q] <= div_ge;
			cnt_q        <= cnt_q - 1'b1;
		end
		if (out_load) begin
			out_data_q <= res_val;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			pend_q  <= issue;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - PCT_W){1'b0}}, out_data_q};

endmodule

>>> hw/rtl/williams_percent_r_top.sv
// ----------------------------------------------------------------------------
// williams_percent_r_top: Williams %R oscillator over a sliding bar window
// Streams price bars in, one %R result per bar out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one beat per bar. tdata = high [31:0], low [63:32],
//     close [95:64]; tuser[0] = new_series, which restarts the history.
//   m_* channel: one beat per bar, tdata[14:0] = %R in hundredths of a
//     percent (signed, -10000..0), tdata[15] = 0.
//   cfg_* channel: writes window_length (7 bits); write only when idle.
// Timing:
//   A bar's back-end time grows with its span (span = min(window, bars in
//   series)); the divider runs only when the result is not a bound. The
//   window scan reads one ring entry per cycle through the RAM read port and
//   the divider yields one quotient bit per cycle; these set the
//   throughput. A two-entry queue lets the front take bars while busy.
// Reset and stall:
//   Reset clears the queue, ring pointer and bar count, window = 14. Ring
//   contents need no clearing. If m_tready is low the result is held, the
//   back end finishes its next bar and waits, and s_tready drops once the
//   queue fills.
// ----------------------------------------------------------------------------
module williams_percent_r_top import wpr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [WIN_W-1:0]      cfg_data,    // window_length
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,     // bar_high, bar_low, bar_close
	input  logic [0:0]            s_tuser,     // new_series
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata      // percent_r, zero pad
);

	logic push;
	logic q_full;
	logic q_valid;
	logic q_pop;
	job_t job_in;
	job_t job_out;

	wpr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.push      (push),
		.job       (job_in)
	);

	wpr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (job_in),
		.full    (q_full),
		.valid   (q_valid),
		.job_out (job_out),
		.pop     (q_pop)
	);

	wpr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_job    (job_out),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

>>> hw/rtl/wpr_checker.sv
// ----------------------------------------------------------------------------
// wpr_checker: port-level checks for the Williams %R block
// Result range, output padding, reset quiet and stall hold.
// ----------------------------------------------------------------------------
module wpr_port_checker import wpr_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [WIN_W-1:0]      cfg_data,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic [0:0]            s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// no result in the cycle after any clock edge that sees reset low
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result beat during reset");

	// result is zero or a negative value no lower than the minimum
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[PCT_W-1:0] == '0) ||
			(m_tdata[PCT_W-1] && ($signed(m_tdata[PCT_W-1:0]) >= $signed(PCT_MIN))))
		else $error("percent_r out of range");

	// pad bit above the result stays clear
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_DATA_W-1:PCT_W] == '0))
		else $error("output pad bits set");

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result beat changed");

endmodule

bind williams_percent_r_top wpr_port_checker u_wpr_checker (.*);
